/* rtl/core/egst_pkg.sv */
// Shared types for the Euclidean gcd step tracer.
// Holds the controller-to-datapath command and status structs and fixed constants.
// No dependencies.
package egst_pkg;

  localparam int unsigned MaxResults = 48;
  localparam int unsigned StepCntW   = 6;

  typedef struct packed {
    logic load;       // capture a new operand pair, larger one as dividend
    logic div_start;  // start a division of the loaded pair
    logic div_step;   // one restoring division iteration
    logic emit;       // move the finished step into the output register
    logic emit_err;   // load the zero-operand error beat
    logic advance;    // divisor becomes dividend, remainder becomes divisor
  } cmd_t;

  typedef struct packed {
    logic den_zero;   // loaded divisor is zero
    logic div_done;   // the current iteration is the last of the division
    logic rem_zero;   // finished remainder is zero
  } sts_t;

endpackage

/* rtl/core/egst_dpath.sv */
// Datapath of the Euclidean gcd step tracer: operand registers, a radix-2
// restoring divider and the output beat register.
// Depends on egst_pkg for the command and status structs.
module egst_dpath #(
  parameter int unsigned WIDTH = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  egst_pkg::cmd_t    cmd_i,
  output egst_pkg::sts_t    sts_o,
  input  logic [WIDTH-1:0]  first_i,
  input  logic [WIDTH-1:0]  second_i,
  output logic [WIDTH-1:0]  dividend_o,
  output logic [WIDTH-1:0]  divisor_o,
  output logic [WIDTH-1:0]  quotient_o,
  output logic [WIDTH-1:0]  remainder_o,
  output logic              last_o,
  output logic              coprime_o,
  output logic              error_o
);

  localparam int unsigned CntW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [WIDTH-1:0] num_q, num_d;
  logic [WIDTH-1:0] den_q, den_d;
  logic [WIDTH-1:0] quo_q, quo_d;
  logic [WIDTH-1:0] rem_q, rem_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [WIDTH:0]   trial;
  logic             ge;

  logic [WIDTH-1:0] out_num_q, out_den_q, out_quo_q, out_rem_q;
  logic             out_last_q, out_cop_q, out_err_q;

  assign trial = {rem_q, quo_q[WIDTH-1]} - {1'b0, den_q};
  assign ge    = ~trial[WIDTH];

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      if (first_i > second_i) begin
        num_d = first_i;
        den_d = second_i;
      end else begin
        num_d = second_i;
        den_d = first_i;
      end
    end else if (cmd_i.div_start) begin
      quo_d = num_q;
      rem_d = '0;
      cnt_d = CntW'(WIDTH - 1);
    end else if (cmd_i.advance) begin
      num_d = den_q;
      den_d = rem_q;
      quo_d = den_q;
      rem_d = '0;
      cnt_d = CntW'(WIDTH - 1);
    end else if (cmd_i.div_step) begin
      rem_d = ge ? trial[WIDTH-1:0] : {rem_q[WIDTH-2:0], quo_q[WIDTH-1]};
      quo_d = {quo_q[WIDTH-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (cmd_i.emit) begin
      out_num_q  <= num_q;
      out_den_q  <= den_q;
      out_quo_q  <= quo_q;
      out_rem_q  <= rem_q;
      out_last_q <= (rem_q == '0);
      out_cop_q  <= (rem_q == '0) && (den_q == WIDTH'(1));
      out_err_q  <= 1'b0;
    end else if (cmd_i.emit_err) begin
      out_num_q  <= '0;
      out_den_q  <= '0;
      out_quo_q  <= '0;
      out_rem_q  <= '0;
      out_last_q <= 1'b1;
      out_cop_q  <= 1'b0;
      out_err_q  <= 1'b1;
    end
  end

  assign sts_o.den_zero = (den_q == '0);
  assign sts_o.div_done = (cnt_q == '0);
  assign sts_o.rem_zero = (rem_q == '0);

  assign dividend_o  = out_num_q;
  assign divisor_o   = out_den_q;
  assign quotient_o  = out_quo_q;
  assign remainder_o = out_rem_q;
  assign last_o      = out_last_q;
  assign coprime_o   = out_cop_q;
  assign error_o     = out_err_q;

endmodule

/* rtl/core/egst_ctrl.sv */
// Controller of the Euclidean gcd step tracer: sequences load, division and
// output beats, and owns the input ready, output valid and step count.
// Depends on egst_pkg for the command and status structs and constants.
module egst_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  egst_pkg::sts_t  sts_i,
  output egst_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CHECK = 5'b00010,
    S_ERR   = 5'b00100,
    S_DIV   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic [egst_pkg::StepCntW-1:0] step_q, step_d;
  logic   out_free;
  logic   limit;

  assign out_free = ~out_valid_q | out_ready_i;
  assign limit    = (step_q == egst_pkg::StepCntW'(egst_pkg::MaxResults - 1));

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q & ~out_ready_i;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        step_d = '0;
        if (sts_i.den_zero) begin
          state_d = S_ERR;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = S_DIV;
        end
      end
      S_ERR: begin
        if (out_free) begin
          cmd_o.emit_err = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.emit  = 1'b1;
          out_valid_d = 1'b1;
          step_d      = step_q + 1'b1;
          if (sts_i.rem_zero || limit) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = S_DIV;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      step_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/euclid_gcd_step_trace.sv */
// Top level of the Euclidean gcd step tracer: stream ports around the
// controller and the datapath.
// Depends on egst_pkg, egst_ctrl and egst_dpath.

// Each input beat carries two unsigned operands; the block emits one output
// beat per division step of the Euclidean algorithm, and tlast marks the step
// whose remainder is zero (its divisor is the gcd). A pair whose smaller
// operand is zero gives a single error beat with zero payload. Division runs
// on one radix-2 restoring divider that resolves one quotient bit per cycle;
// at WIDTH 32 the worst case is about 47 steps. One pair is worked at a time,
// and the next pair is accepted while the final beat still waits in the output
// register.
module euclid_gcd_step_trace #(
  parameter int unsigned WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // first_value, second_value
  input  logic [((2 * WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // dividend, divisor, quotient, remainder
  output logic [((4 * WIDTH + 7) / 8) * 8 - 1:0] m_axis_tdata,
  output logic                                  m_axis_tlast,
  // coprime, zero_operand_error
  output logic [1:0]                            m_axis_tuser
);

  localparam int unsigned MDataW = ((4 * WIDTH + 7) / 8) * 8;

  egst_pkg::cmd_t   cmd;
  egst_pkg::sts_t   sts;
  logic [WIDTH-1:0] dividend, divisor, quotient, remainder;
  logic             coprime, zero_err;

  egst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  egst_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .first_i     (s_axis_tdata[WIDTH-1:0]),
    .second_i    (s_axis_tdata[2*WIDTH-1:WIDTH]),
    .dividend_o  (dividend),
    .divisor_o   (divisor),
    .quotient_o  (quotient),
    .remainder_o (remainder),
    .last_o      (m_axis_tlast),
    .coprime_o   (coprime),
    .error_o     (zero_err)
  );

  assign m_axis_tdata = MDataW'({remainder, quotient, divisor, dividend});
  assign m_axis_tuser = {zero_err, coprime};

  a_err_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && zero_err |-> m_axis_tlast && dividend == '0 && divisor == '0)
    else $error("error beat without tlast or with nonzero payload");

  a_coprime_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && coprime |-> m_axis_tlast && !zero_err && divisor == WIDTH'(1))
    else $error("coprime flag on a beat that is not a final gcd of one");

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !zero_err |-> remainder < divisor)
    else $error("remainder not below divisor");

  a_one_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("new pair accepted while one is in progress");

endmodule
